// ===== rtl/sliding_window_congestion_sender_core_macros.svh =====
// Assertion macros shared by the sender core modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SLIDING_WINDOW_CONGESTION_SENDER_CORE_MACROS_SVH
`define SLIDING_WINDOW_CONGESTION_SENDER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define SWCS_ASSERT_IMP(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

`define SWCS_ASSERT_NXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define SWCS_ASSERT_IMP(name, cond, conseq, msg)

`define SWCS_ASSERT_NXT(name, cond, conseq, msg)

`endif

`endif

// ===== rtl/swcs_pkg.sv =====
package swcs_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;

  // Event kinds carried on in_tuser.
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_ACK     = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SEGMENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SSTHRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIMEOUT    = 3'd4;

  localparam logic [15:0] RST_TOTAL_SEGMENTS  = 16'd1;
  localparam logic [5:0]  RST_WINDOW_SEGMENTS = 6'd8;
  localparam logic [10:0] RST_SEGMENT_BYTES   = 11'd1500;
  localparam logic [31:0] RST_SSTHRESH        = 32'd64000;
  localparam logic [31:0] RST_TIMEOUT         = 32'd2000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMPACK,
    ST_EVENT,
    ST_RCMP,
    ST_RMAG,
    ST_RAPPLY,
    ST_TMO,
    ST_BOUND,
    ST_CLIP,
    ST_DONE,
    ST_CHECK,
    ST_SEND,
    ST_STATUS
  } state_t;

  // Which quantity the RTT sequence is working on.
  typedef enum logic [1:0] {
    PH_EST,
    PH_DIFF,
    PH_DEV
  } rtt_phase_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ge;
    logic        zero;
  } alu_rsp_t;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] send_seq;
    logic        final_segment;
    logic        last_of_run;
    logic [15:0] cwnd_now;
    logic [31:0] timeout_now_us;
    logic        transfer_done;
  } res_t;

endpackage

// ===== rtl/sliding_window_congestion_sender_core.sv =====
// Each event runs the states CMPACK, EVENT, BOUND, CLIP, DONE and CHECK before its
// first result is loaded; an acknowledgement that grows the window and updates the RTT
// estimate also runs RCMP, RMAG, RAPPLY and TMO between EVENT and BOUND. A new event is
// taken only in IDLE, once all results (1 to MAX_WINDOW) of the last are loaded; one shared adder serves every step.
// Reset: synchronous, active low; loads register and state defaults, empties output.
`include "sliding_window_congestion_sender_core_macros.svh"

module sliding_window_congestion_sender_core import swcs_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata: ack_number[15:0], rtt_sample_us[39:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: send_seq[15:0], final_segment[16], cwnd_now[32:17],
  //            timeout_now_us[64:33], transfer_done[65], zero fill[71:66]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: send_valid
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int LIM_W = $clog2(MAX_WINDOW + 1);

  // Configuration registers.
  logic [15:0] total_r;
  logic [5:0]  window_r;
  logic [10:0] segb_r;
  logic [31:0] init_ss_r;
  logic [31:0] init_to_r;

  // Connection state.
  state_t      state_r, state_nxt;
  logic [15:0] next_seq_r, next_seq_nxt;
  logic [15:0] first_unacked_r, first_unacked_nxt;
  logic [15:0] cwnd_r, cwnd_nxt;
  logic [31:0] ssthresh_r, ssthresh_nxt;
  logic [23:0] est_r, est_nxt;
  logic [23:0] dev_r, dev_nxt;
  logic [31:0] timeout_r, timeout_nxt;

  // Latched event and sequencer work registers.
  logic [1:0]  req_r, req_nxt;
  logic [15:0] ack_r, ack_nxt;
  logic [23:0] sample_r, sample_nxt;
  logic [26:0] prod_r, prod_nxt;
  logic        ack_ge_r, ack_ge_nxt;
  logic        ack_eq_r, ack_eq_nxt;
  logic        ge_r, ge_nxt;
  logic [23:0] mag_r, mag_nxt;
  rtt_phase_t  phase_r, phase_nxt;
  logic [16:0] bound_r, bound_nxt;
  logic [15:0] end_r, end_nxt;
  logic        clip_r, clip_nxt;
  logic        done_r, done_nxt;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic        ob_load;
  logic        ob_free;
  res_t        ob_din;

  logic [15:0]      win_ext;
  logic [15:0]      lim16;
  logic [LIM_W-1:0] lim;
  logic             lim_is_cwnd;
  logic [16:0]      grow_sum;
  logic [23:0]      x_val;
  logic [23:0]      y_val;
  logic             seq_last;

  swcs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  swcs_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ob_load),
    .din        (ob_din),
    .free       (ob_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Send limit: the smallest of cwnd, the receiver window and MAX_WINDOW.
  always_comb begin
    win_ext = {10'd0, window_r};
    lim16   = (cwnd_r < win_ext) ? cwnd_r : win_ext;
    if (16'(MAX_WINDOW) < lim16) begin
      lim16 = 16'(MAX_WINDOW);
    end
    lim         = lim16[LIM_W-1:0];
    lim_is_cwnd = (cwnd_r <= win_ext) && (cwnd_r <= 16'(MAX_WINDOW));
  end

  // The RTT sequence compares x with y, forms |x - y| and then, for the estimate and the deviation, moves the target.
  always_comb begin
    x_val = (phase_r == PH_DEV) ? mag_r : sample_r;
    y_val = (phase_r == PH_DEV) ? dev_r : est_r;
  end

  assign seq_last = (({1'b0, next_seq_r} + 17'd1) == {1'b0, end_r});

  always_comb begin
    state_nxt         = state_r;
    next_seq_nxt      = next_seq_r;
    first_unacked_nxt = first_unacked_r;
    cwnd_nxt          = cwnd_r;
    ssthresh_nxt      = ssthresh_r;
    est_nxt           = est_r;
    dev_nxt           = dev_r;
    timeout_nxt       = timeout_r;
    req_nxt           = req_r;
    ack_nxt           = ack_r;
    sample_nxt        = sample_r;
    prod_nxt          = prod_r;
    ack_ge_nxt        = ack_ge_r;
    ack_eq_nxt        = ack_eq_r;
    ge_nxt            = ge_r;
    mag_nxt           = mag_r;
    phase_nxt         = phase_r;
    bound_nxt         = bound_r;
    end_nxt           = end_r;
    clip_nxt          = clip_r;
    done_nxt          = done_r;
    grow_sum          = 17'd0;
    alu_req           = '{a: 32'd0, b: 32'd0, sub: 1'b1};
    ob_load           = 1'b0;
    ob_din            = '{send_valid: 1'b0, send_seq: 16'd0, final_segment: 1'b0,
                          last_of_run: 1'b1, cwnd_now: cwnd_r,
                          timeout_now_us: timeout_r, transfer_done: done_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt    = in_tuser;
          ack_nxt    = in_tdata[15:0];
          sample_nxt = in_tdata[39:16];
          state_nxt  = ST_CMPACK;
        end
      end

      ST_CMPACK: begin
        alu_req    = '{a: 32'(ack_r), b: 32'(next_seq_r), sub: 1'b1};
        ack_ge_nxt = alu_rsp.ge;
        ack_eq_nxt = alu_rsp.zero;
        prod_nxt   = 27'(cwnd_r) * 27'(segb_r);
        state_nxt  = ST_EVENT;
      end

      ST_EVENT: begin
        // The adder checks cwnd*segment_bytes against ssthresh for the growth rule.
        alu_req   = '{a: 32'(prod_r), b: ssthresh_r, sub: 1'b1};
        state_nxt = ST_BOUND;
        case (req_r)
          REQ_START: begin
            next_seq_nxt      = 16'd0;
            first_unacked_nxt = 16'd0;
            cwnd_nxt          = 16'd1;
            ssthresh_nxt      = init_ss_r;
            est_nxt           = 24'd0;
            dev_nxt           = 24'd0;
            timeout_nxt       = init_to_r;
          end
          REQ_TIMEOUT: begin
            ssthresh_nxt = 32'(prod_r[26:1]);
            cwnd_nxt     = 16'd1;
            timeout_nxt  = timeout_r[31] ? 32'hFFFF_FFFF : {timeout_r[30:0], 1'b0};
          end
          REQ_ACK: begin
            first_unacked_nxt = ack_r;
            next_seq_nxt      = ack_r;
            if (!ack_ge_r) begin
              ssthresh_nxt = 32'(prod_r[26:1]);
              cwnd_nxt     = 16'd1;
              timeout_nxt  = timeout_r[31] ? 32'hFFFF_FFFF : {timeout_r[30:0], 1'b0};
            end else if (!ack_eq_r && lim_is_cwnd) begin
              grow_sum  = alu_rsp.ge ? ({1'b0, cwnd_r} + 17'd1) : {cwnd_r, 1'b0};
              cwnd_nxt  = grow_sum[16] ? 16'hFFFF : grow_sum[15:0];
              phase_nxt = PH_EST;
              state_nxt = ST_RCMP;
            end
          end
          default: begin
          end
        endcase
      end

      ST_RCMP: begin
        alu_req   = '{a: 32'(x_val), b: 32'(y_val), sub: 1'b1};
        ge_nxt    = alu_rsp.ge;
        state_nxt = ST_RMAG;
      end

      ST_RMAG: begin
        if (ge_r) begin
          alu_req = '{a: 32'(x_val), b: 32'(y_val), sub: 1'b1};
        end else begin
          alu_req = '{a: 32'(y_val), b: 32'(x_val), sub: 1'b1};
        end
        mag_nxt = alu_rsp.res[23:0];
        if (phase_r == PH_DIFF) begin
          phase_nxt = PH_DEV;
          state_nxt = ST_RCMP;
        end else begin
          state_nxt = ST_RAPPLY;
        end
      end

      ST_RAPPLY: begin
        // Shifting the magnitude makes a negative step round toward zero.
        if (phase_r == PH_EST) begin
          alu_req   = '{a: 32'(est_r), b: 32'(mag_r[23:3]), sub: !ge_r};
          est_nxt   = alu_rsp.res[23:0];
          phase_nxt = PH_DIFF;
          state_nxt = ST_RCMP;
        end else begin
          alu_req   = '{a: 32'(dev_r), b: 32'(mag_r[23:2]), sub: !ge_r};
          dev_nxt   = alu_rsp.res[23:0];
          state_nxt = ST_TMO;
        end
      end

      ST_TMO: begin
        // est and dev stay below 2^24, so est + 4*dev stays below 2^27 and cannot reach the 32-bit limit.
        alu_req     = '{a: 32'(est_r), b: 32'({dev_r, 2'b00}), sub: 1'b0};
        timeout_nxt = alu_rsp.res;
        state_nxt   = ST_BOUND;
      end

      ST_BOUND: begin
        alu_req   = '{a: 32'(first_unacked_r), b: 32'(lim), sub: 1'b0};
        bound_nxt = alu_rsp.res[16:0];
        state_nxt = ST_CLIP;
      end

      ST_CLIP: begin
        alu_req   = '{a: 32'(bound_r), b: 32'(total_r), sub: 1'b1};
        clip_nxt  = alu_rsp.ge;
        end_nxt   = alu_rsp.ge ? total_r : bound_r[15:0];
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // The transfer ends this event if the run reaches the total or already has.
        alu_req   = '{a: 32'(next_seq_r), b: 32'(total_r), sub: 1'b1};
        done_nxt  = clip_r | alu_rsp.ge;
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        alu_req   = '{a: 32'(next_seq_r), b: 32'(end_r), sub: 1'b1};
        state_nxt = alu_rsp.ge ? ST_STATUS : ST_SEND;
      end

      ST_SEND: begin
        ob_din = '{send_valid: 1'b1, send_seq: next_seq_r,
                   final_segment: seq_last && clip_r, last_of_run: seq_last,
                   cwnd_now: cwnd_r, timeout_now_us: timeout_r,
                   transfer_done: done_r};
        if (ob_free) begin
          ob_load      = 1'b1;
          next_seq_nxt = next_seq_r + 16'd1;
          if (seq_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_STATUS: begin
        if (ob_free) begin
          ob_load   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      next_seq_r      <= 16'd0;
      first_unacked_r <= 16'd0;
      cwnd_r          <= 16'd1;
      ssthresh_r      <= RST_SSTHRESH;
      est_r           <= 24'd0;
      dev_r           <= 24'd0;
      timeout_r       <= RST_TIMEOUT;
    end else begin
      state_r         <= state_nxt;
      next_seq_r      <= next_seq_nxt;
      first_unacked_r <= first_unacked_nxt;
      cwnd_r          <= cwnd_nxt;
      ssthresh_r      <= ssthresh_nxt;
      est_r           <= est_nxt;
      dev_r           <= dev_nxt;
      timeout_r       <= timeout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    ack_r    <= ack_nxt;
    sample_r <= sample_nxt;
    prod_r   <= prod_nxt;
    ack_ge_r <= ack_ge_nxt;
    ack_eq_r <= ack_eq_nxt;
    ge_r     <= ge_nxt;
    mag_r    <= mag_nxt;
    phase_r  <= phase_nxt;
    bound_r  <= bound_nxt;
    end_r    <= end_nxt;
    clip_r   <= clip_nxt;
    done_r   <= done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= RST_TOTAL_SEGMENTS;
      window_r  <= RST_WINDOW_SEGMENTS;
      segb_r    <= RST_SEGMENT_BYTES;
      init_ss_r <= RST_SSTHRESH;
      init_to_r <= RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOTAL_SEGMENTS:  total_r   <= cfg_data[15:0];
        CFG_WINDOW_SEGMENTS: window_r  <= cfg_data[5:0];
        CFG_SEGMENT_BYTES:   segb_r    <= cfg_data[10:0];
        CFG_INIT_SSTHRESH:   init_ss_r <= cfg_data;
        CFG_INIT_TIMEOUT:    init_to_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  `SWCS_ASSERT_IMP(a_send_in_run, state_r == ST_SEND, next_seq_r < end_r, "sending past the end of the run")

  `SWCS_ASSERT_IMP(a_status_empty, state_r == ST_STATUS, next_seq_r >= end_r, "status result while a segment was sendable")

  `SWCS_ASSERT_NXT(a_timeout_cwnd, state_r == ST_EVENT && req_r == REQ_TIMEOUT, cwnd_r == 16'd1 && state_r == ST_BOUND, "timeout did not collapse the window")

endmodule

// ===== rtl/swcs_alu.sv =====
module swcs_alu import swcs_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] sum;

  // For a subtraction the carry out is set when a >= b.
  always_comb begin
    sum      = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {32'd0, req.sub};
    rsp.res  = sum[31:0];
    rsp.ge   = sum[32];
    rsp.zero = (sum[31:0] == 32'd0);
  end

endmodule

// ===== rtl/swcs_obuf.sv =====
`include "sliding_window_congestion_sender_core_macros.svh"

module swcs_obuf import swcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  res_t                   din,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: send_seq[15:0], final_segment[16], cwnd_now[32:17],
  //            timeout_now_us[64:33], transfer_done[65], zero fill[71:66]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: send_valid
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic valid_r, valid_nxt;
  res_t hold_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= din;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = hold_r.send_valid;
  assign out_tlast  = hold_r.last_of_run;
  assign out_tdata  = {6'd0, hold_r.transfer_done, hold_r.timeout_now_us,
                       hold_r.cwnd_now, hold_r.final_segment, hold_r.send_seq};

  `SWCS_ASSERT_IMP(a_final_is_last, valid_r && hold_r.final_segment, hold_r.last_of_run && hold_r.send_valid, "final segment not marked as last sent result")

endmodule

// ===== sim/sliding_window_congestion_sender_core_monitor.sv =====
`timescale 1ns / 100ps

module sliding_window_congestion_sender_core_monitor import swcs_pkg::*; #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data,
  output int unsigned            mismatches,
  output int unsigned            awaited,
  output int unsigned            results_seen,
  output logic [15:0]            sent_upto
);

  res_t send_plan[$];

  logic [31:0] tot_segs, win_segs, seg_bytes, init_ssth, init_tmo;
  logic [31:0] nxt, una, cwnd, ssth, est, dev, rto;

  int unsigned miss_count = 0;
  int unsigned plan_depth = 0;
  int unsigned seen_count = 0;

  assign mismatches   = miss_count;
  assign awaited      = plan_depth;
  assign results_seen = seen_count;
  assign sent_upto    = nxt[15:0];

  function automatic logic [31:0] send_cap();
    logic [31:0] m;
    m = cwnd;
    if (win_segs < m) m = win_segs;
    if (MAX_WINDOW < m) m = MAX_WINDOW;
    return m;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    miss_count++;
    if (miss_count <= 30)
      $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic note_loss();
    ssth = (cwnd * seg_bytes) >> 1;
    cwnd = 32'd1;
    rto  = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto << 1;
  endtask

  // Both gains shift the magnitude, so a shrinking step rounds toward zero.
  task automatic track_rtt(input logic [31:0] s);
    logic [31:0] diff;
    logic [34:0] t;
    if (s >= est) est = est + ((s - est) >> 3);
    else est = est - ((est - s) >> 3);
    diff = (s >= est) ? s - est : est - s;
    if (diff >= dev) dev = dev + ((diff - dev) >> 2);
    else dev = dev - ((dev - diff) >> 2);
    t = {3'd0, est} + {1'b0, dev, 2'b00};
    rto = (t > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endtask

  task automatic plan_event(input logic [1:0] kind, input logic [15:0] ack,
                            input logic [23:0] smp);
    res_t burst[$];
    res_t r;
    logic [31:0] lim, bound, ack32;
    logic done;
    ack32 = {16'd0, ack};
    case (kind)
      REQ_START: begin
        nxt  = '0;
        una  = '0;
        cwnd = 32'd1;
        ssth = init_ssth;
        est  = '0;
        dev  = '0;
        rto  = init_tmo;
      end
      REQ_TIMEOUT: note_loss();
      REQ_ACK: begin
        lim = send_cap();
        if (ack32 < nxt) begin
          note_loss();
        end else if (lim == cwnd && ack32 > nxt) begin
          if (cwnd * seg_bytes >= ssth) cwnd = cwnd + 1;
          else cwnd = cwnd << 1;
          if (cwnd > 32'hFFFF) cwnd = 32'hFFFF;
          track_rtt({8'd0, smp});
        end
        una = ack32;
        nxt = ack32;
      end
      default: ;
    endcase

    bound = una + send_cap();
    while (nxt < bound && nxt < tot_segs) begin
      r = '0;
      r.send_valid     = 1'b1;
      r.send_seq       = nxt[15:0];
      r.final_segment  = (nxt == tot_segs - 32'd1);
      r.cwnd_now       = cwnd[15:0];
      r.timeout_now_us = rto;
      burst.push_back(r);
      nxt = nxt + 1;
    end
    if (burst.size() == 0) begin
      r = '0;
      r.cwnd_now       = cwnd[15:0];
      r.timeout_now_us = rto;
      burst.push_back(r);
    end
    done = (nxt >= tot_segs);
    foreach (burst[k]) begin
      r = burst[k];
      r.transfer_done = done;
      r.last_of_run   = (k == burst.size() - 1);
      send_plan.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      tot_segs  = {16'd0, RST_TOTAL_SEGMENTS};
      win_segs  = {26'd0, RST_WINDOW_SEGMENTS};
      seg_bytes = {21'd0, RST_SEGMENT_BYTES};
      init_ssth = RST_SSTHRESH;
      init_tmo  = RST_TIMEOUT;
      nxt  = '0;
      una  = '0;
      cwnd = 32'd1;
      ssth = RST_SSTHRESH;
      est  = '0;
      dev  = '0;
      rto  = RST_TIMEOUT;
      send_plan.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOTAL_SEGMENTS:  tot_segs  = {16'd0, cfg_data[15:0]};
          CFG_WINDOW_SEGMENTS: win_segs  = {26'd0, cfg_data[5:0]};
          CFG_SEGMENT_BYTES:   seg_bytes = {21'd0, cfg_data[10:0]};
          CFG_INIT_SSTHRESH:   init_ssth = cfg_data;
          CFG_INIT_TIMEOUT:    init_tmo  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        plan_event(in_tuser, in_tdata[15:0], in_tdata[39:16]);
      if (out_tvalid && out_tready) begin
        seen_count++;
        if (send_plan.size() == 0) begin
          report_mismatch("result transaction with nothing expected, send_seq",
                          {16'd0, out_tdata[15:0]}, 32'd0);
        end else begin
          want = send_plan.pop_front();
          if (out_tuser !== want.send_valid)
            report_mismatch("send_valid", 32'(out_tuser), 32'(want.send_valid));
          if (out_tdata[15:0] !== want.send_seq)
            report_mismatch("send_seq", 32'(out_tdata[15:0]), 32'(want.send_seq));
          if (out_tdata[16] !== want.final_segment)
            report_mismatch("final_segment", 32'(out_tdata[16]),
                            32'(want.final_segment));
          if (out_tlast !== want.last_of_run)
            report_mismatch("last_of_run", 32'(out_tlast), 32'(want.last_of_run));
          if (out_tdata[32:17] !== want.cwnd_now)
            report_mismatch("cwnd_now", 32'(out_tdata[32:17]), 32'(want.cwnd_now));
          if (out_tdata[64:33] !== want.timeout_now_us)
            report_mismatch("timeout_now_us", out_tdata[64:33], want.timeout_now_us);
          if (out_tdata[65] !== want.transfer_done)
            report_mismatch("transfer_done", 32'(out_tdata[65]),
                            32'(want.transfer_done));
        end
      end
    end
    plan_depth = send_plan.size();
  end

endmodule

// ===== sim/sliding_window_congestion_sender_core_test.sv =====
`timescale 1ns / 100ps

module sliding_window_congestion_sender_core_test;
  import swcs_pkg::*;

  // The block ignores this kind apart from re-running its send phase.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASES       = 8;
  localparam int PHASE_EVENTS = 30;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [31:0]            cfg_data;

  logic in_took  = 1'b0;
  logic cfg_took = 1'b0;
  bit   idling   = 1'b1;
  int   stall_left = 0;
  int   quiet      = 0;

  int unsigned mismatches, awaited, results_seen;
  logic [15:0] sent_upto;
  int n_start = 0, n_tmo = 0, n_ack = 0, n_other = 0, n_writes = 0;

  sliding_window_congestion_sender_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sliding_window_congestion_sender_core_monitor window_watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .results_seen (results_seen),
    .sent_upto    (sent_upto)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Handshake flags are read back at the following falling edge.
  always @(posedge clk) begin
    in_took  <= in_tvalid && in_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  always @(negedge clk) begin
    if (!idling) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_event(input logic [1:0] kind, input logic [15:0] ack,
                            input logic [23:0] rtt);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {rtt, ack};
    do begin
      @(negedge clk);
    end while (!in_took);
    case (kind)
      REQ_START:   n_start++;
      REQ_TIMEOUT: n_tmo++;
      REQ_ACK:     n_ack++;
      default:     n_other++;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
    end while (!cfg_took);
    n_writes++;
  endtask

  task automatic program_regs(input logic [15:0] total, input logic [5:0] window,
                              input logic [10:0] seg, input logic [31:0] ssth,
                              input logic [31:0] tmo);
    write_reg(CFG_TOTAL_SEGMENTS, {16'd0, total});
    write_reg(CFG_WINDOW_SEGMENTS, {26'd0, window});
    write_reg(CFG_SEGMENT_BYTES, {21'd0, seg});
    write_reg(CFG_INIT_SSTHRESH, ssth);
    write_reg(CFG_INIT_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  // Registers may only change once every outstanding result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] ack_ahead(input int step);
    int v;
    v = sent_upto + step;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // Mostly acks just past the send pointer, which grow the window; the rest
  // are losses, repeats, restarts, unknown kinds and arbitrary values.
  task automatic random_event();
    int pick;
    logic [15:0] ack;
    logic [23:0] rtt;
    pick = $urandom_range(0, 99);
    ack  = 16'($urandom());
    rtt  = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(200, 400000));
    if (pick < 6) begin
      push_event(REQ_START, ack, rtt);
    end else if (pick < 14) begin
      push_event(REQ_TIMEOUT, ack, rtt);
    end else if (pick < 17) begin
      push_event(REQ_UNKNOWN, ack, rtt);
    end else if (pick < 24) begin
      push_event(REQ_ACK, ack, rtt);
    end else if (pick < 33) begin
      ack = (sent_upto == 0) ? 16'd0 : 16'($urandom_range(0, sent_upto - 1));
      push_event(REQ_ACK, ack, rtt);
    end else if (pick < 40) begin
      push_event(REQ_ACK, sent_upto, rtt);
    end else begin
      push_event(REQ_ACK, ack_ahead($urandom_range(1, 4)), rtt);
    end
  endtask

  task automatic phase_regs(input int p);
    case (p)
      0: program_regs(16'd200, 6'd16, 11'd1500, 32'd64000, 32'd2000000);
      1: program_regs(16'hFFFF, 6'd32, 11'd2047, 32'd0, 32'd1);
      2: program_regs(16'd60000, 6'd63, 11'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      3: program_regs(16'($urandom_range(0, 60)), 6'($urandom_range(0, 63)),
                      11'($urandom_range(0, 2047)), $urandom(), $urandom());
      default: program_regs(16'($urandom_range(1, 400)), 6'($urandom_range(1, 40)),
                            11'($urandom_range(1, 2047)), $urandom_range(0, 200000),
                            $urandom());
    endcase
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_START;
    cfg_valid = 1'b0;
    cfg_index = CFG_TOTAL_SEGMENTS;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One-segment transfer with the register defaults, then an unknown kind.
    push_event(REQ_START, 16'hFFFF, 24'hFFFFFF);
    push_event(REQ_UNKNOWN, 16'h0000, 24'h000000);

    // Oversized receiver window: the window grows until the send cap holds it.
    settle();
    program_regs(16'hFFFF, 6'd63, 11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_event(REQ_START, 16'h0000, 24'h000000);
    for (int k = 0; k < 6; k++)
      push_event(REQ_ACK, ack_ahead(1),
                 (k == 0) ? 24'hFFFFFF : (k == 1) ? 24'd0 :
                 24'($urandom_range(1, 100000)));
    push_event(REQ_TIMEOUT, 16'h0000, 24'h000000);
    push_event(REQ_TIMEOUT, 16'hFFFF, 24'hFFFFFF);
    push_event(REQ_ACK, 16'h0000, 24'd5000);
    push_event(REQ_ACK, sent_upto, 24'd5000);
    push_event(REQ_ACK, 16'hFFFF, 24'd5000);
    push_event(REQ_UNKNOWN, 16'hFFFF, 24'hFFFFFF);

    // Zero window and empty transfer: only status results come back.
    settle();
    program_regs(16'd0, 6'd0, 11'd0, 32'd0, 32'd1);
    push_event(REQ_START, 16'h0000, 24'h000000);
    push_event(REQ_ACK, 16'd5, 24'd100);
    push_event(REQ_TIMEOUT, 16'h0000, 24'h000000);

    // Short transfer that runs to its final segment with linear growth.
    settle();
    program_regs(16'd3, 6'd1, 11'd1, 32'd0, 32'd100);
    push_event(REQ_START, 16'h0000, 24'h000000);
    push_event(REQ_ACK, 16'd2, 24'd300);
    push_event(REQ_ACK, 16'd3, 24'd300);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      idling = (p != 4) && (p != PHASES - 1);
      phase_regs(p);
      push_event(REQ_START, 16'($urandom()), 24'($urandom()));
      repeat (PHASE_EVENTS - 1) random_event();
    end

    in_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("sent %0d events: %0d start, %0d timeout, %0d ack, %0d unknown kind",
             n_start + n_tmo + n_ack + n_other, n_start, n_tmo, n_ack, n_other);
    $display("%0d register writes, %0d result transactions compared", n_writes,
             results_seen);
    if (mismatches == 0 && awaited == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
